// ===== rtl/wg_pkg.sv =====
package wg_pkg;

    // Table and field geometry
    localparam int TABLE_LENGTH = 32;
    localparam int PHASE_W      = $clog2(TABLE_LENGTH);
    localparam int LEVEL_W      = 8;
    localparam int DUTY_W       = 5;
    localparam int MODE_W       = 3;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 8;

    // Fixed levels
    localparam logic [LEVEL_W-1:0] MID_LEVEL  = 8'd128;
    localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'hFF;
    localparam logic [LEVEL_W-1:0] ZERO_LEVEL = 8'd0;

    // Mode selector positions
    localparam logic [MODE_W-1:0] MODE_IDLE = 3'd7;
    localparam logic [MODE_W-1:0] MODE_LAST = 3'd3;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_DUTY_COMPARE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP    = 1'b1;

    // Configuration reset values
    localparam logic [DUTY_W-1:0]  DUTY_RESET = 5'd15;
    localparam logic [LEVEL_W-1:0] RAMP_RESET = 8'd8;

    // Event kinds
    localparam logic FUNC_TICK   = 1'b0;
    localparam logic FUNC_BUTTON = 1'b1;

    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_RAMP     = 2'd2,
        WAVE_SINE     = 2'd3
    } wave_kind_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase_index;
        logic [LEVEL_W-1:0] triangle_level;
        logic [LEVEL_W-1:0] ramp_level;
        logic               output_enabled;
        logic [MODE_W-1:0]  mode_position;
        wave_kind_t         wave_kind;
    } wg_state_t;

    // Triangle rising step: floor(255 / (duty + 1))
    function automatic logic [LEVEL_W-1:0] tri_up_step(input logic [DUTY_W-1:0] duty);
        logic [LEVEL_W-1:0] s;
        case (duty)
            5'd0:  s = 8'd255;
            5'd1:  s = 8'd127;
            5'd2:  s = 8'd85;
            5'd3:  s = 8'd63;
            5'd4:  s = 8'd51;
            5'd5:  s = 8'd42;
            5'd6:  s = 8'd36;
            5'd7:  s = 8'd31;
            5'd8:  s = 8'd28;
            5'd9:  s = 8'd25;
            5'd10: s = 8'd23;
            5'd11: s = 8'd21;
            5'd12: s = 8'd19;
            5'd13: s = 8'd18;
            5'd14: s = 8'd17;
            5'd15: s = 8'd15;
            5'd16: s = 8'd15;
            5'd17: s = 8'd14;
            5'd18: s = 8'd13;
            5'd19: s = 8'd12;
            5'd20: s = 8'd12;
            5'd21: s = 8'd11;
            5'd22: s = 8'd11;
            5'd23: s = 8'd10;
            5'd24: s = 8'd10;
            5'd25: s = 8'd9;
            5'd26: s = 8'd9;
            5'd27: s = 8'd9;
            5'd28: s = 8'd8;
            5'd29: s = 8'd8;
            5'd30: s = 8'd8;
            5'd31: s = 8'd7;
            default: s = 8'd7;
        endcase
        return s;
    endfunction

    // Triangle falling step: ceil(255 / (33 - duty))
    function automatic logic [LEVEL_W-1:0] tri_down_step(input logic [DUTY_W-1:0] duty);
        logic [LEVEL_W-1:0] s;
        case (duty)
            5'd0:  s = 8'd8;
            5'd1:  s = 8'd8;
            5'd2:  s = 8'd9;
            5'd3:  s = 8'd9;
            5'd4:  s = 8'd9;
            5'd5:  s = 8'd10;
            5'd6:  s = 8'd10;
            5'd7:  s = 8'd10;
            5'd8:  s = 8'd11;
            5'd9:  s = 8'd11;
            5'd10: s = 8'd12;
            5'd11: s = 8'd12;
            5'd12: s = 8'd13;
            5'd13: s = 8'd13;
            5'd14: s = 8'd14;
            5'd15: s = 8'd15;
            5'd16: s = 8'd15;
            5'd17: s = 8'd16;
            5'd18: s = 8'd17;
            5'd19: s = 8'd19;
            5'd20: s = 8'd20;
            5'd21: s = 8'd22;
            5'd22: s = 8'd24;
            5'd23: s = 8'd26;
            5'd24: s = 8'd29;
            5'd25: s = 8'd32;
            5'd26: s = 8'd37;
            5'd27: s = 8'd43;
            5'd28: s = 8'd51;
            5'd29: s = 8'd64;
            5'd30: s = 8'd85;
            5'd31: s = 8'd128;
            default: s = 8'd128;
        endcase
        return s;
    endfunction

    // One period of sine, offset binary
    function automatic logic [LEVEL_W-1:0] sine_lookup(input logic [PHASE_W-1:0] ph);
        logic [LEVEL_W-1:0] s;
        case (ph)
            5'd0:  s = 8'd127;
            5'd1:  s = 8'd151;
            5'd2:  s = 8'd175;
            5'd3:  s = 8'd197;
            5'd4:  s = 8'd216;
            5'd5:  s = 8'd232;
            5'd6:  s = 8'd244;
            5'd7:  s = 8'd251;
            5'd8:  s = 8'd254;
            5'd9:  s = 8'd251;
            5'd10: s = 8'd244;
            5'd11: s = 8'd232;
            5'd12: s = 8'd216;
            5'd13: s = 8'd197;
            5'd14: s = 8'd175;
            5'd15: s = 8'd151;
            5'd16: s = 8'd127;
            5'd17: s = 8'd102;
            5'd18: s = 8'd78;
            5'd19: s = 8'd56;
            5'd20: s = 8'd37;
            5'd21: s = 8'd21;
            5'd22: s = 8'd9;
            5'd23: s = 8'd2;
            5'd24: s = 8'd0;
            5'd25: s = 8'd2;
            5'd26: s = 8'd9;
            5'd27: s = 8'd21;
            5'd28: s = 8'd37;
            5'd29: s = 8'd56;
            5'd30: s = 8'd78;
            5'd31: s = 8'd102;
            default: s = 8'd127;
        endcase
        return s;
    endfunction

endpackage

// ===== rtl/waveform_generator.sv =====
// Channel   Handshake                 Word fields
// --------  ------------------------  ----------------------------------
// input     in_valid  / in_stall      func, toggle_pressed, mode_pressed
// output    out_valid / out_stall     sample
// config    cfg_we (no handshake)     cfg_index, cfg_data
//
// One word per cycle is accepted unless in_stall holds it; a tick's sample
// passes through the input register, then the sample register.
// Throughput is set by the single update of the wave state per cycle, made only while go is high.
// Button words leave the sample register untouched and give no output word.
// rst_n clears valid flags and wave state (mode to idle); duty compare resets to 15, ramp step to 8.
// in_stall rises only while the sample register is full and stalled.
module waveform_generator (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             func,
    input  logic                             toggle_pressed,
    input  logic                             mode_pressed,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [wg_pkg::LEVEL_W-1:0]       sample,
    input  logic                             cfg_we,
    input  logic [wg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [wg_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import wg_pkg::*;

    logic                 in_valid_reg;
    logic                 func_reg;
    logic                 toggle_reg;
    logic                 mode_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [LEVEL_W-1:0]   sample_reg;
    logic [DUTY_W-1:0]    duty_reg;
    logic [LEVEL_W-1:0]   ramp_step_reg;
    wg_state_t            state_reg;
    wg_state_t            state_next;
    logic                 core_has_word;
    logic [LEVEL_W-1:0]   core_sample;
    logic                 go;

    // Stage advances unless the sample register is full and held
    assign go       = in_valid_reg & ~(out_valid_reg & out_stall);
    assign in_stall = in_valid_reg & out_valid_reg & out_stall;

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg      <= DUTY_RESET;
            ramp_step_reg <= RAMP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DUTY_COMPARE: duty_reg      <= cfg_data[DUTY_W-1:0];
                REG_RAMP_STEP:    ramp_step_reg <= cfg_data[LEVEL_W-1:0];
                default:          ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            func_reg   <= func;
            toggle_reg <= toggle_pressed;
            mode_reg   <= mode_pressed;
        end
    end

    wg_core u_core (
        .func           (func_reg),
        .toggle_pressed (toggle_reg),
        .mode_pressed   (mode_reg),
        .state          (state_reg),
        .duty_compare   (duty_reg),
        .ramp_step      (ramp_step_reg),
        .state_next     (state_next),
        .has_word       (core_has_word),
        .sample         (core_sample)
    );

    // Wave state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase_index    <= '0;
            state_reg.triangle_level <= '0;
            state_reg.ramp_level     <= '0;
            state_reg.output_enabled <= 1'b0;
            state_reg.mode_position  <= MODE_IDLE;
            state_reg.wave_kind      <= WAVE_SQUARE;
        end
        else if (go)
        begin
            state_reg <= state_next;
        end
    end

    // Sample register
    always_comb
    begin
        if (go)
        begin
            out_valid_next = core_has_word;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && core_has_word)
        begin
            sample_reg <= core_sample;
        end
    end

`ifndef SYNTHESIS
    // Tick with the output off gives the mid level
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && func_reg == FUNC_TICK && !state_reg.output_enabled)
        |=> (out_valid && sample == MID_LEVEL))
    else $error("off tick did not give mid level");

    // Button words never produce an output word
    assert property (@(posedge clk) disable iff (!rst_n)
        (go && func_reg == FUNC_BUTTON) |=> !out_valid)
    else $error("button word produced output");

    // Mode selector never rests at an unused position
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.mode_position <= MODE_LAST) || (state_reg.mode_position == MODE_IDLE))
    else $error("mode position out of range");

    // Stall only while a word sits in the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_valid_reg)
    else $error("stall without a held word");

    // Wave state moves only when a word is processed
    assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(state_reg))
    else $error("wave state changed without a word");
`endif

endmodule

// ===== rtl/wg_core.sv =====
module wg_core (
    input  logic                        func,
    input  logic                        toggle_pressed,
    input  logic                        mode_pressed,
    input  wg_pkg::wg_state_t           state,
    input  logic [wg_pkg::DUTY_W-1:0]   duty_compare,
    input  logic [wg_pkg::LEVEL_W-1:0]  ramp_step,
    output wg_pkg::wg_state_t           state_next,
    output logic                        has_word,
    output logic [wg_pkg::LEVEL_W-1:0]  sample
);
    import wg_pkg::*;

    logic                 in_high_half;
    logic [LEVEL_W:0]     tri_sum;
    logic [LEVEL_W-1:0]   tri_up;
    logic [LEVEL_W-1:0]   tri_dn;
    logic [LEVEL_W-1:0]   tri_new;
    logic [LEVEL_W-1:0]   ramp_new;
    logic [PHASE_W-1:0]   phase_inc;
    logic [MODE_W-1:0]    mode_inc;

    // Shared terms
    assign in_high_half = (state.phase_index <= duty_compare);
    assign tri_up       = tri_up_step(duty_compare);
    assign tri_dn       = tri_down_step(duty_compare);
    assign tri_sum      = {1'b0, state.triangle_level} + {1'b0, tri_up};
    assign ramp_new     = state.ramp_level + ramp_step;
    assign phase_inc    = state.phase_index + PHASE_W'(1);
    assign mode_inc     = state.mode_position + MODE_W'(1);

    // Triangle with saturation at both rails
    always_comb
    begin
        if (in_high_half)
        begin
            tri_new = tri_sum[LEVEL_W] ? FULL_LEVEL : tri_sum[LEVEL_W-1:0];
        end
        else
        begin
            tri_new = (state.triangle_level > tri_dn) ?
                      (state.triangle_level - tri_dn) : ZERO_LEVEL;
        end
    end

    // Event decode and state update
    always_comb
    begin
        state_next = state;
        has_word   = 1'b0;
        sample     = MID_LEVEL;
        if (func == FUNC_BUTTON)
        begin
            // toggle first, then mode step
            if (toggle_pressed)
            begin
                state_next.output_enabled = ~state.output_enabled;
            end
            if (mode_pressed)
            begin
                if (mode_inc <= MODE_LAST)
                begin
                    state_next.mode_position = mode_inc;
                    state_next.wave_kind     = wave_kind_t'(mode_inc[1:0]);
                end
                else
                begin
                    state_next.mode_position = MODE_IDLE;
                end
            end
        end
        else
        begin
            has_word = 1'b1;
            if (state.output_enabled)
            begin
                case (state.wave_kind)
                    WAVE_SQUARE:
                    begin
                        sample = in_high_half ? FULL_LEVEL : ZERO_LEVEL;
                    end
                    WAVE_TRIANGLE:
                    begin
                        sample                    = tri_new;
                        state_next.triangle_level = tri_new;
                    end
                    WAVE_RAMP:
                    begin
                        sample                = ramp_new;
                        state_next.ramp_level = ramp_new;
                    end
                    WAVE_SINE:
                    begin
                        sample = sine_lookup(state.phase_index);
                    end
                    default:
                    begin
                        sample = MID_LEVEL;
                    end
                endcase
                // phase wrap restarts the triangle
                state_next.phase_index = phase_inc;
                if (phase_inc == '0)
                begin
                    state_next.triangle_level = ZERO_LEVEL;
                end
            end
        end
    end

endmodule
